/* rtl/core/lrr_pkg.sv */
// Shared types and constants for the label region renderer.
// Used by lrr_shade and label_region_render; depends on nothing.
package lrr_pkg;

  localparam int LABEL_W   = 32;
  localparam int MAX_WIDTH = 4096;
  localparam int COL_W     = 12;
  localparam int SIZE_W    = 13;
  localparam int LEVEL_W   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 13;

  localparam logic [SIZE_W-1:0]  SIZE_MAX     = 13'd4096;
  localparam logic [SIZE_W-1:0]  RESET_SIZE   = 13'd256;
  localparam logic [LEVEL_W-1:0] LEVEL_LOW    = 8'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_HIGH   = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH     = 3'd0,
    REG_IMAGE_HEIGHT    = 3'd1,
    REG_BORDER_LEVEL    = 3'd2,
    REG_UNCERTAIN_LEVEL = 3'd3,
    REG_CERTAIN_LEVEL   = 3'd4,
    REG_NEGATIVE_LEVEL  = 3'd5,
    REG_NEGATIVE_FIXED  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] border_level;
    logic [LEVEL_W-1:0] uncertain_level;
    logic [LEVEL_W-1:0] certain_level;
    logic [LEVEL_W-1:0] negative_level;
    logic               negative_fixed;
  } levels_t;

  // Everything the shading logic needs about one pixel
  typedef struct packed {
    logic [LABEL_W-1:0] cur;
    logic [LABEL_W-1:0] up;
    logic [LABEL_W-1:0] left;
    logic [LABEL_W-1:0] upleft;
    logic               on_edge;
    logic               odd;
  } pix_t;

endpackage

/* rtl/core/lrr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; holds the previous row of labels.
module lrr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/lrr_shade.sv */
// Picks the display intensity of one pixel from its neighbourhood.
// Depends on lrr_pkg.
module lrr_shade (
  input  lrr_pkg::pix_t                 pix,
  input  lrr_pkg::levels_t              levels,
  output logic [lrr_pkg::LEVEL_W-1:0]   intensity
);

  logic negative;
  logic border;

  assign negative = pix.cur[lrr_pkg::LABEL_W-1];
  assign border   = pix.on_edge || (pix.left != pix.cur) || (pix.up != pix.cur)
                    || (pix.upleft != pix.cur);

  always_comb begin
    if (negative) begin
      if (levels.negative_fixed) begin
        intensity = levels.negative_level;
      end else begin
        intensity = pix.odd ? lrr_pkg::LEVEL_HIGH : lrr_pkg::LEVEL_LOW;
      end
    end else if (border) begin
      intensity = levels.border_level;
    end else if (pix.cur == '0) begin
      intensity = levels.uncertain_level;
    end else begin
      intensity = levels.certain_level;
    end
  end

endmodule

/* rtl/core/label_region_render.sv */
// Top level of the label region renderer: counters, line buffer, pipeline.
// Depends on lrr_pkg, lrr_ram and lrr_shade.
//
//   channel  | valid          | stall          | payload
//   ---------+----------------+----------------+-------------------------
//   input    | label_valid    | label_stall    | label
//   result   | result_valid   | result_stall   | intensity, frame_end
//   config   | cfg_write      | -              | cfg_index, cfg_data
//
// One item per cycle unless result_stall holds it; each item passes stage 1
// and the output register. The line buffer read is issued at acceptance and
// used in stage 1; a write still in flight to the same column is forwarded.
// Reset clears counters, neighbour labels and valids; the line buffer is not
// cleared (row zero is an edge and never uses it).
// A stalled result holds the pipeline stage behind it and then the input.
module label_region_render (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [lrr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lrr_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            label_valid,
  output logic                            label_stall,
  input  logic signed [lrr_pkg::LABEL_W-1:0] label,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [lrr_pkg::LEVEL_W-1:0]     intensity,
  output logic                            frame_end
);

  // configuration
  logic [lrr_pkg::SIZE_W-1:0] image_width;
  logic [lrr_pkg::SIZE_W-1:0] image_height;
  lrr_pkg::levels_t           levels;

  // input side counters
  logic [lrr_pkg::COL_W-1:0]  column_count;
  logic [lrr_pkg::COL_W-1:0]  row_count;
  logic [lrr_pkg::SIZE_W-1:0] width_eff;
  logic [lrr_pkg::SIZE_W-1:0] height_eff;
  logic                       last_col;
  logic                       last_row;
  logic                       accept;

  // stage 1
  logic                       s1_valid;
  logic [lrr_pkg::LABEL_W-1:0] s1_label;
  logic [lrr_pkg::COL_W-1:0]  s1_x;
  logic                       s1_edge;
  logic                       s1_odd;
  logic                       s1_frame_end;
  logic                       s1_adv;
  logic                       out_free;
  logic                       fwd_hit;
  logic [lrr_pkg::LABEL_W-1:0] fwd_data;
  logic [lrr_pkg::LABEL_W-1:0] ram_q;
  logic [lrr_pkg::LABEL_W-1:0] up_label;
  logic [lrr_pkg::LABEL_W-1:0] left_label;
  logic [lrr_pkg::LABEL_W-1:0] upleft_label;
  lrr_pkg::pix_t              pix;
  logic [lrr_pkg::LEVEL_W-1:0] shade;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width            <= lrr_pkg::RESET_SIZE;
      image_height           <= lrr_pkg::RESET_SIZE;
      levels.border_level    <= lrr_pkg::LEVEL_LOW;
      levels.uncertain_level <= lrr_pkg::LEVEL_LOW;
      levels.certain_level   <= lrr_pkg::LEVEL_HIGH;
      levels.negative_level  <= lrr_pkg::LEVEL_LOW;
      levels.negative_fixed  <= 1'b0;
    end else if (cfg_write) begin
      case (lrr_pkg::cfg_reg_t'(cfg_index))
        lrr_pkg::REG_IMAGE_WIDTH:     image_width            <= cfg_data;
        lrr_pkg::REG_IMAGE_HEIGHT:    image_height           <= cfg_data;
        lrr_pkg::REG_BORDER_LEVEL:    levels.border_level    <= cfg_data[7:0];
        lrr_pkg::REG_UNCERTAIN_LEVEL: levels.uncertain_level <= cfg_data[7:0];
        lrr_pkg::REG_CERTAIN_LEVEL:   levels.certain_level   <= cfg_data[7:0];
        lrr_pkg::REG_NEGATIVE_LEVEL:  levels.negative_level  <= cfg_data[7:0];
        lrr_pkg::REG_NEGATIVE_FIXED:  levels.negative_fixed  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // zero counts as one, anything above the buffer size as the buffer size
  always_comb begin
    if (image_width == '0) begin
      width_eff = lrr_pkg::SIZE_W'(1);
    end else if (image_width > lrr_pkg::SIZE_MAX) begin
      width_eff = lrr_pkg::SIZE_MAX;
    end else begin
      width_eff = image_width;
    end
    if (image_height == '0) begin
      height_eff = lrr_pkg::SIZE_W'(1);
    end else if (image_height > lrr_pkg::SIZE_MAX) begin
      height_eff = lrr_pkg::SIZE_MAX;
    end else begin
      height_eff = image_height;
    end
  end

  assign last_col = ({1'b0, column_count} + lrr_pkg::SIZE_W'(1)) >= width_eff;
  assign last_row = ({1'b0, row_count} + lrr_pkg::SIZE_W'(1)) >= height_eff;

  assign out_free    = !result_valid || !result_stall;
  assign s1_adv      = s1_valid && out_free;
  assign label_stall = s1_valid && !out_free;
  assign accept      = label_valid && !label_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_count + lrr_pkg::COL_W'(1);
      end else begin
        column_count <= column_count + lrr_pkg::COL_W'(1);
      end
    end
  end

  lrr_ram #(
    .WIDTH (lrr_pkg::LABEL_W),
    .DEPTH (lrr_pkg::MAX_WIDTH)
  ) u_row_store (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_x),
    .wr_data (s1_label),
    .rd_en   (accept),
    .rd_addr (column_count),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_label     <= label;
      s1_x         <= column_count;
      s1_edge      <= (column_count == '0) || (row_count == '0) || last_col || last_row;
      s1_odd       <= column_count[0] ^ row_count[0];
      s1_frame_end <= last_col && last_row;
      // previous pixel writes this column on the same edge as we read it
      fwd_hit      <= s1_adv && (s1_x == column_count);
      fwd_data     <= s1_label;
    end
  end

  assign up_label = fwd_hit ? fwd_data : ram_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_label   <= '0;
      upleft_label <= '0;
    end else if (s1_adv) begin
      left_label   <= s1_label;
      upleft_label <= up_label;
    end
  end

  always_comb begin
    pix.cur     = s1_label;
    pix.up      = up_label;
    pix.left    = left_label;
    pix.upleft  = upleft_label;
    pix.on_edge = s1_edge;
    pix.odd     = s1_odd;
  end

  lrr_shade u_shade (
    .pix       (pix),
    .levels    (levels),
    .intensity (shade)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      intensity <= shade;
      frame_end <= s1_frame_end;
    end
  end

`ifndef ASSERT_OFF
  a_hold_when_blocked: assert property (@(posedge clk) disable iff (rst)
    s1_valid && result_valid && result_stall |-> label_stall)
    else $error("input taken while pipeline is blocked");

  a_col_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && last_col |=> column_count == '0)
    else $error("column counter did not wrap on last column");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && last_col && last_row |=> row_count == '0)
    else $error("row counter did not wrap at frame end");

  a_stage_drains: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_free && !accept |=> !s1_valid)
    else $error("stage 1 kept an item that moved on");
`endif

endmodule

/* tb/tb_label_region_render.sv */
`timescale 1ns / 100ps
// Self-checking testbench for label_region_render: a directed table, a wide run, then random phases.
// Depends on lrr_pkg and the RTL under rtl/core; outputs are compared with a line-buffer model.
module tb_label_region_render;
  import lrr_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int WIDE_ITEMS     = 160;
  localparam int RANDOM_ITEMS   = 1170;
  localparam int DIR_ROWS       = 30;

  typedef enum logic {ROW_PIXEL, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    cfg_reg_t           idx;
    logic [LABEL_W-1:0] value;
    logic               typed;
    logic [LEVEL_W-1:0] intensity;
    logic               frame_end;
  } dir_row_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] intensity;
    logic               frame_end;
  } pixel_out_t;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               cfg_write    = 1'b0;
  cfg_reg_t           cfg_index    = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0]   cfg_data     = '0;
  logic               label_valid  = 1'b0;
  logic               label_stall;
  logic [LABEL_W-1:0] label        = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic [LEVEL_W-1:0] intensity;
  logic               frame_end;

  label_region_render u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .label_valid  (label_valid),
    .label_stall  (label_stall),
    .label        (label),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .intensity    (intensity),
    .frame_end    (frame_end)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Model of the renderer: registers, line buffer, neighbours, raster position
  logic [SIZE_W-1:0]  img_w    = RESET_SIZE;
  logic [SIZE_W-1:0]  img_h    = RESET_SIZE;
  levels_t            lv       = '{LEVEL_LOW, LEVEL_LOW, LEVEL_HIGH, LEVEL_LOW, 1'b0};
  logic [LABEL_W-1:0] prev_row [MAX_WIDTH];
  logic [LABEL_W-1:0] left_lab = '0;
  logic [LABEL_W-1:0] diag_lab = '0;
  int                 col_pos  = 0;
  int                 row_pos  = 0;
  int                 cols_filled = 0;  // line buffer entries written so far form a prefix

  pixel_out_t         pixel_out_q [$];
  int                 errors   = 0;
  bit                 quiet    = 1'b0;
  logic [LABEL_W-1:0] palette [4];
  int                 region_w = 2;
  int                 region_h = 2;
  dir_row_t           directed [DIR_ROWS];

  function automatic int eff_size(input logic [SIZE_W-1:0] s);
    if (s == '0) return 1;
    if (s > SIZE_MAX) return MAX_WIDTH;
    return int'(s);
  endfunction

  task automatic render_pixel(input logic [LABEL_W-1:0] cur, output pixel_out_t px);
    int w, h;
    logic [LABEL_W-1:0] up;
    logic last_col, last_row;
    w = eff_size(img_w);
    h = eff_size(img_h);
    up = prev_row[col_pos];
    last_col = (col_pos + 1 >= w);
    last_row = (row_pos + 1 >= h);
    if (col_pos == 0 || row_pos == 0 || last_col || last_row ||
        left_lab != cur || up != cur || diag_lab != cur)
      px.intensity = lv.border_level;
    else if (cur == '0)
      px.intensity = lv.uncertain_level;
    else
      px.intensity = lv.certain_level;
    // negative labels override border and interior shading
    if (cur[LABEL_W-1])
      px.intensity = lv.negative_fixed ? lv.negative_level :
                     (((col_pos + row_pos) % 2) != 0 ? LEVEL_HIGH : LEVEL_LOW);
    px.frame_end = last_col && last_row;
    diag_lab = up;
    left_lab = cur;
    prev_row[col_pos] = cur;
    if (col_pos >= cols_filled) cols_filled = col_pos + 1;
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : (row_pos + 1) % MAX_WIDTH;
    end else begin
      col_pos++;
    end
  endtask

  function automatic int idle_len();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size(input int hi);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return SIZE_W'($urandom_range(4096, 8191));
    return SIZE_W'($urandom_range(1, hi));
  endfunction

  function automatic logic [LEVEL_W-1:0] pick_level();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return LEVEL_LOW;
    if (r == 1) return LEVEL_HIGH;
    return LEVEL_W'($urandom_range(0, 255));
  endfunction

  // Mostly blocky regions so that interior pixels occur, with some noise
  function automatic logic [LABEL_W-1:0] next_label();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return palette[((col_pos / region_w) + (row_pos / region_h)) % 4];
    if (r < 85) return '0;
    if (r < 95) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '1;
      default: return 32'd1;
    endcase
  endfunction

  task automatic fresh_regions();
    palette[0] = '0;
    palette[1] = ($urandom & 32'h7FFF_FFFF) | 32'd1;
    palette[2] = $urandom | 32'h8000_0000;
    palette[3] = $urandom;
    region_w = $urandom_range(2, 5);
    region_h = $urandom_range(2, 5);
  endtask

  task automatic send_pixel(input logic [LABEL_W-1:0] lab, input logic typed,
                            input pixel_out_t typed_px);
    pixel_out_t px;
    int gap;
    label_valid <= 1'b1;
    label       <= lab;
    do @(posedge clk); while (label_stall);
    render_pixel(lab, px);
    pixel_out_q.push_back(typed ? typed_px : px);
    gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap > 0) begin
      label_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    label_valid <= 1'b0;
    while (pixel_out_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // caller drops cfg_write after the last write of a group
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH:     img_w = data[SIZE_W-1:0];
      REG_IMAGE_HEIGHT:    img_h = data[SIZE_W-1:0];
      REG_BORDER_LEVEL:    lv.border_level = data[LEVEL_W-1:0];
      REG_UNCERTAIN_LEVEL: lv.uncertain_level = data[LEVEL_W-1:0];
      REG_CERTAIN_LEVEL:   lv.certain_level = data[LEVEL_W-1:0];
      REG_NEGATIVE_LEVEL:  lv.negative_level = data[LEVEL_W-1:0];
      REG_NEGATIVE_FIXED:  lv.negative_fixed = data[0];
      default: ;
    endcase
  endtask

  task automatic random_config();
    logic [SIZE_W-1:0] s;
    if ($urandom_range(0, 1) != 0) begin
      s = pick_size(12);
      // widening below row zero must not reach unwritten line buffer entries
      if (row_pos == 0 || eff_size(s) <= cols_filled) write_reg(REG_IMAGE_WIDTH, s);
    end
    if ($urandom_range(0, 1) != 0) write_reg(REG_IMAGE_HEIGHT, pick_size(10));
    for (int i = REG_BORDER_LEVEL; i <= REG_NEGATIVE_LEVEL; i++)
      if ($urandom_range(0, 1) != 0) write_reg(cfg_reg_t'(i), CFG_W'(pick_level()));
    if ($urandom_range(0, 2) == 0) write_reg(REG_NEGATIVE_FIXED, CFG_W'($urandom_range(0, 1)));
    cfg_write <= 1'b0;
  endtask

  // Result side: random back-pressure, off while quiet
  int stall_left = 0;
  bit stall_on   = 1'b0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      if (quiet || $urandom_range(0, 2) != 0) begin
        stall_on   = 1'b0;
        stall_left = quiet ? 4 : $urandom_range(1, 12);
      end else begin
        stall_on   = 1'b1;
        stall_left = idle_len();
      end
    end else begin
      stall_left--;
    end
    result_stall <= stall_on;
  end

  always @(posedge clk) begin
    pixel_out_t exp_px;
    if (!rst && result_valid && !result_stall) begin
      if (pixel_out_q.size() == 0) begin
        $error("result item with no pixel pending");
        errors++;
      end else begin
        exp_px = pixel_out_q.pop_front();
        if (intensity !== exp_px.intensity) begin
          $error("intensity: expected %0d, got %0d", exp_px.intensity, intensity);
          errors++;
        end
        if (frame_end !== exp_px.frame_end) begin
          $error("frame_end: expected %0d, got %0d", exp_px.frame_end, frame_end);
          errors++;
        end
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((label_valid && !label_stall) || (result_valid && !result_stall) || cfg_write)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_label_region_render NOT OK");
      $finish;
    end
  end

  initial begin
    dir_row_t   row;
    pixel_out_t tpx;
    int         sent;
    int         n;
    bit         in_cfg;
    // after reset the first pixel is an edge drawn with the default border level;
    // the rest walks 3x3 frames, then 1x1 frames from zero sizes
    directed = '{
      '{ROW_PIXEL, REG_IMAGE_WIDTH,     32'd5,          1'b1, 8'h00, 1'b0},
      '{ROW_CFG,   REG_IMAGE_WIDTH,     32'd3,          1'b0, 8'h00, 1'b0},
      '{ROW_CFG,   REG_IMAGE_HEIGHT,    32'd3,          1'b0, 8'h00, 1'b0},
      '{ROW_CFG,   REG_BORDER_LEVEL,    32'h11,         1'b0, 8'h00, 1'b0},
      '{ROW_CFG,   REG_UNCERTAIN_LEVEL, 32'h22,         1'b0, 8'h00, 1'b0},
      '{ROW_CFG,   REG_CERTAIN_LEVEL,   32'h33,         1'b0, 8'h00, 1'b0},
      '{ROW_CFG,   REG_NEGATIVE_LEVEL,  32'h44,         1'b0, 8'h00, 1'b0},
      '{ROW_CFG,   REG_NEGATIVE_FIXED,  32'd0,          1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL, REG_IMAGE_WIDTH,     32'd5,          1'b1, 8'h11, 1'b0},
      '{ROW_PIXEL, REG_IMAGE_WIDTH,     32'd5,          1'b1, 8'h11, 1'b0},
      '{ROW_PIXEL, REG_IMAGE_WIDTH,     32'd5,          1'b1, 8'h11, 1'b0},
      '{ROW_PIXEL, REG_IMAGE_WIDTH,     32'd5,          1'b1, 8'h33, 1'b0},
      '{ROW_PIXEL, REG_IMAGE_WIDTH,     32'd5,          1'b1, 8'h11, 1'b0},
      '{ROW_PIXEL, REG_IMAGE_WIDTH,     32'd5,          1'b1, 8'h11, 1'b0},
      '{ROW_PIXEL, REG_IMAGE_WIDTH,     32'd5,          1'b1, 8'h11, 1'b0},
      '{ROW_PIXEL, REG_IMAGE_WIDTH,     32'd5,          1'b1, 8'h11, 1'b1},
      '{ROW_PIXEL, REG_IMAGE_WIDTH,     32'd0,          1'b1, 8'h11, 1'b0},
      '{ROW_PIXEL, REG_IMAGE_WIDTH,     32'd0,          1'b1, 8'h11, 1'b0},
      '{ROW_PIXEL, REG_IMAGE_WIDTH,     32'hFFFF_FFFF,  1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL, REG_IMAGE_WIDTH,     32'd0,          1'b1, 8'h11, 1'b0},
      '{ROW_PIXEL, REG_IMAGE_WIDTH,     32'd0,          1'b1, 8'h22, 1'b0},
      '{ROW_PIXEL, REG_IMAGE_WIDTH,     32'h7FFF_FFFF,  1'b1, 8'h11, 1'b0},
      '{ROW_PIXEL, REG_IMAGE_WIDTH,     32'h8000_0000,  1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL, REG_IMAGE_WIDTH,     32'hFFFF_FFFF,  1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL, REG_IMAGE_WIDTH,     32'd0,          1'b1, 8'h11, 1'b1},
      '{ROW_CFG,   REG_NEGATIVE_FIXED,  32'd1,          1'b0, 8'h00, 1'b0},
      '{ROW_CFG,   REG_IMAGE_WIDTH,     32'd0,          1'b0, 8'h00, 1'b0},
      '{ROW_CFG,   REG_IMAGE_HEIGHT,    32'd0,          1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL, REG_IMAGE_WIDTH,     32'hFFFF_FFFB,  1'b1, 8'h44, 1'b1},
      '{ROW_PIXEL, REG_IMAGE_WIDTH,     32'h7FFF_FFFF,  1'b1, 8'h11, 1'b1}
    };
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    in_cfg = 1'b0;
    foreach (directed[i]) begin
      row = directed[i];
      if (row.kind == ROW_CFG) begin
        if (!in_cfg) begin
          drain_results();
          in_cfg = 1'b1;
        end
        write_reg(row.idx, row.value[CFG_W-1:0]);
      end else begin
        if (in_cfg) begin
          cfg_write <= 1'b0;
          in_cfg = 1'b0;
        end
        tpx.intensity = row.intensity;
        tpx.frame_end = row.frame_end;
        send_pixel(row.value, row.typed, tpx);
      end
    end

    // a run at the widest setting (clamped), without idling
    drain_results();
    write_reg(REG_IMAGE_WIDTH, '1);
    write_reg(REG_IMAGE_HEIGHT, 13'd1);
    cfg_write <= 1'b0;
    quiet = 1'b1;
    fresh_regions();
    repeat (WIDE_ITEMS) send_pixel(next_label(), 1'b0, '0);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_results();
      random_config();
      quiet = ($urandom_range(0, 4) == 0);
      fresh_regions();
      n = $urandom_range(20, 120);
      repeat (n) begin
        if ($urandom_range(0, 59) == 0) drain_results();
        send_pixel(next_label(), 1'b0, '0);
        sent++;
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("tb_label_region_render OK");
    else
      $display("tb_label_region_render NOT OK");
    $finish;
  end

endmodule

/* label_region_render.f */
rtl/core/lrr_pkg.sv
rtl/core/lrr_ram.sv
rtl/core/lrr_shade.sv
rtl/core/label_region_render.sv
tb/tb_label_region_render.sv
